[hw/rtl/lpes_pkg.sv]
// Shared types, constants and helpers for the loop phase event sorter.
`timescale 1ns / 1ps
package lpes_pkg;

  localparam int MAX_EVENTS = 64;
  localparam int IDX_W      = $clog2(MAX_EVENTS);
  localparam int CNT_W      = $clog2(MAX_EVENTS + 1);
  localparam int TICK_W     = 32;
  localparam int KIND_W     = 2;
  localparam int RANK_W     = 2;
  localparam int MOD_CNT_W  = $clog2(TICK_W);

  localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OTHER    = 2'd2;

  typedef struct packed {
    logic [TICK_W-1:0] event_tick;
    logic [KIND_W-1:0] event_kind;
    logic              last_event;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  sorted_index;
    logic [TICK_W-1:0] event_phase;
    logic              last_result;
  } out_rsp_t;

  // One slot of the sorted row
  typedef struct packed {
    logic              occupied;
    logic [TICK_W-1:0] phase;
    logic [TICK_W-1:0] tick;
    logic [RANK_W-1:0] rank;
    logic [IDX_W-1:0]  arrival;
  } cell_t;

  typedef enum logic [1:0] {
    ROW_HOLD,
    ROW_INSERT,
    ROW_SHIFT
  } row_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_INSERT,
    ST_EMIT
  } state_t;

  // Anything beyond note-on sorts as "other"
  function automatic logic [RANK_W-1:0] kind_rank(input logic [KIND_W-1:0] kind);
    logic [RANK_W-1:0] r;
    r = (kind == KIND_NOTE_OFF) ? KIND_NOTE_OFF :
        (kind == KIND_NOTE_ON)  ? KIND_NOTE_ON  : KIND_OTHER;
    return r;
  endfunction

  // Strict lexicographic compare on phase, tick, rank
  function automatic logic key_after(input cell_t held, input cell_t cand);
    logic r;
    r = {held.phase, held.tick, held.rank} > {cand.phase, cand.tick, cand.rank};
    return r;
  endfunction

endpackage

[hw/rtl/lpes_modulo.sv]
// Restoring remainder unit: one quotient bit per cycle.
`timescale 1ns / 1ps
module lpes_modulo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lpes_pkg::TICK_W-1:0] dividend,
  input  logic [lpes_pkg::TICK_W-1:0] divisor,
  output logic                      done,
  output logic [lpes_pkg::TICK_W-1:0] remainder
);

  logic                           run_r, run_nxt;
  logic                           done_r, done_nxt;
  logic [lpes_pkg::MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [lpes_pkg::TICK_W-1:0]    dvd_r, dvd_nxt;
  logic [lpes_pkg::TICK_W-1:0]    dsr_r, dsr_nxt;
  logic [lpes_pkg::TICK_W-1:0]    rem_r, rem_nxt;
  logic [lpes_pkg::TICK_W:0]      trial;
  logic [lpes_pkg::TICK_W:0]      diff;

  assign trial = {rem_r, dvd_r[lpes_pkg::TICK_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = dividend;
      dsr_nxt = divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      dvd_nxt = {dvd_r[lpes_pkg::TICK_W-2:0], 1'b0};
      rem_nxt = diff[lpes_pkg::TICK_W] ? trial[lpes_pkg::TICK_W-1:0]
                                       : diff[lpes_pkg::TICK_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == lpes_pkg::MOD_CNT_W'(lpes_pkg::TICK_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

[hw/rtl/lpes_cell.sv]
// One slot of the sorted row: compare, shift up on insert, shift down on emit.
`timescale 1ns / 1ps
module lpes_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  lpes_pkg::row_op_t op,
  input  lpes_pkg::cell_t   new_entry,
  input  lpes_pkg::cell_t   prev_entry,
  input  logic              prev_after,
  input  lpes_pkg::cell_t   next_entry,
  output lpes_pkg::cell_t   entry,
  output logic              after
);

  lpes_pkg::cell_t data_r, data_nxt;
  logic            occ_r;

  // Empty slots sort after everything
  assign after = !occ_r || lpes_pkg::key_after(data_r, new_entry);

  always_comb begin
    data_nxt          = data_r;
    data_nxt.occupied = occ_r;
    case (op)
      lpes_pkg::ROW_INSERT: begin
        if (prev_after) begin
          data_nxt = prev_entry;
        end else if (after) begin
          data_nxt = new_entry;
        end
      end
      lpes_pkg::ROW_SHIFT: begin
        data_nxt = next_entry;
      end
      default: begin
        data_nxt.occupied = occ_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= data_nxt.occupied;
    end
    data_r <= data_nxt;
  end

  always_comb begin
    entry          = data_r;
    entry.occupied = occ_r;
  end

endmodule

[hw/rtl/loop_phase_event_sorter.sv]
// Top level: phase unit, sorted row of cells and emission sequencer.
`timescale 1ns / 1ps
// Usage notes
//  - Requests enter on in_req, taken at an edge with start high and busy low.
//  - Each request's phase is tick mod loop length, found by a restoring
//    remainder unit at one bit per cycle, or is the tick itself when the loop
//    length is zero. Busy stays high from the accepting edge until the request
//    is inserted or dropped and emission is over; no request is taken meanwhile.
//  - The request is inserted into a row of 64 cells at once; every cell
//    compares against the broadcast key and shifts up by one where needed.
//  - On a request marked last, the row shifts down one cell per cycle and
//    cell 0 is presented on out_rsp with out_valid high for one cycle each,
//    one result per held event, last_result on the
//    final one. The row is empty afterwards.
//  - Results cannot be held off; each is marked valid for one cycle only.
//  - A request arriving with 64 events held is dropped (emission still
//    happens if it is marked last).
//  - cfg_data writes the loop length whenever cfg_valid is high; the length
//    is sampled when each request is accepted.
//  - Synchronous reset empties the row and clears the loop length.
module loop_phase_event_sorter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  lpes_pkg::in_req_t             in_req,
  output logic                          out_valid,
  output lpes_pkg::out_rsp_t            out_rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpes_pkg::TICK_W-1:0]   cfg_data
);

  localparam int N = lpes_pkg::MAX_EVENTS;

  lpes_pkg::state_t                state_r, state_nxt;
  logic [lpes_pkg::TICK_W-1:0]     loop_len_r;
  logic [lpes_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [lpes_pkg::TICK_W-1:0]     tick_r, tick_nxt;
  logic [lpes_pkg::TICK_W-1:0]     phase_r, phase_nxt;
  logic [lpes_pkg::RANK_W-1:0]     rank_r, rank_nxt;
  logic                            last_r, last_nxt;
  logic                            out_valid_r, out_valid_nxt;
  lpes_pkg::out_rsp_t              out_rsp_r, out_rsp_nxt;
  lpes_pkg::row_op_t               row_op;
  lpes_pkg::cell_t                 new_entry;
  lpes_pkg::cell_t                 empty_entry;
  lpes_pkg::cell_t                 entries [N];
  logic                            afters  [N];
  logic                            accept;
  logic                            mod_start;
  logic                            mod_done;
  logic [lpes_pkg::TICK_W-1:0]     mod_rem;
  logic                            row_full;

  assign accept    = start && (state_r == lpes_pkg::ST_IDLE);
  assign busy      = (state_r != lpes_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign row_full  = (count_r == lpes_pkg::CNT_W'(N));
  assign mod_start = accept && (loop_len_r != '0);

  lpes_modulo u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (in_req.event_tick),
    .divisor   (loop_len_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_comb begin
    empty_entry          = '0;
    new_entry.occupied   = 1'b1;
    new_entry.phase      = phase_r;
    new_entry.tick       = tick_r;
    new_entry.rank       = rank_r;
    new_entry.arrival    = count_r[lpes_pkg::IDX_W-1:0];
  end

  // Row of cells; cell 0 holds the earliest entry
  for (genvar i = 0; i < N; i++) begin : g_cell
    lpes_pkg::cell_t prev_e;
    lpes_pkg::cell_t next_e;
    logic            prev_a;
    if (i == 0) begin : g_first
      assign prev_e = empty_entry;
      assign prev_a = 1'b0;
    end else begin : g_mid
      assign prev_e = entries[i-1];
      assign prev_a = afters[i-1];
    end
    if (i == N - 1) begin : g_last
      assign next_e = empty_entry;
    end else begin : g_inner
      assign next_e = entries[i+1];
    end
    lpes_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (row_op),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .prev_after (prev_a),
      .next_entry (next_e),
      .entry      (entries[i]),
      .after      (afters[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    tick_nxt      = tick_r;
    phase_nxt     = phase_r;
    rank_nxt      = rank_r;
    last_nxt      = last_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    row_op        = lpes_pkg::ROW_HOLD;
    case (state_r)
      lpes_pkg::ST_IDLE: begin
        if (accept) begin
          tick_nxt  = in_req.event_tick;
          phase_nxt = in_req.event_tick;
          rank_nxt  = lpes_pkg::kind_rank(in_req.event_kind);
          last_nxt  = in_req.last_event;
          state_nxt = (loop_len_r == '0) ? lpes_pkg::ST_INSERT : lpes_pkg::ST_MOD;
        end
      end
      lpes_pkg::ST_MOD: begin
        if (mod_done) begin
          phase_nxt = mod_rem;
          state_nxt = lpes_pkg::ST_INSERT;
        end
      end
      lpes_pkg::ST_INSERT: begin
        if (!row_full) begin
          row_op    = lpes_pkg::ROW_INSERT;
          count_nxt = count_r + 1'b1;
        end
        if (last_r && (count_nxt != '0)) begin
          state_nxt = lpes_pkg::ST_EMIT;
        end else begin
          state_nxt = lpes_pkg::ST_IDLE;
        end
      end
      lpes_pkg::ST_EMIT: begin
        row_op                   = lpes_pkg::ROW_SHIFT;
        out_valid_nxt            = 1'b1;
        out_rsp_nxt.sorted_index = entries[0].arrival;
        out_rsp_nxt.event_phase  = entries[0].phase;
        out_rsp_nxt.last_result  = (count_r == lpes_pkg::CNT_W'(1));
        count_nxt                = count_r - 1'b1;
        if (count_r == lpes_pkg::CNT_W'(1)) begin
          state_nxt = lpes_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lpes_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpes_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      loop_len_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        loop_len_r <= cfg_data;
      end
    end
    tick_r    <= tick_nxt;
    phase_r   <= phase_nxt;
    rank_r    <= rank_nxt;
    last_r    <= last_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
